### sv/svt_pkg.sv
// Shared types, command codes and sizes for the sprite vertex transform.
`default_nettype none
package svt_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned N_DIM         = 4;
    localparam int unsigned ROW_W         = 2;

    // Both queues are a power of two deep so that the pointers wrap by themselves.
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned RES_DEPTH = 4;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_LSB = 2;

    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_USE_SCENE_GRAPH = '0;

    localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
    localparam logic [1:0] CMD_NODE     = 2'd1;
    localparam logic [1:0] CMD_VERTEX   = 2'd2;

    typedef logic signed [DATA_W-1:0] t_svt_word;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  row_index;
        t_svt_word   operand_a;
        t_svt_word   operand_b;
        t_svt_word   operand_c;
        t_svt_word   operand_d;
        t_svt_word   operand_e;
        t_svt_word   operand_f;
        logic        last_vertex;
    } t_svt_item;

    typedef struct packed {
        t_svt_word out_x;
        t_svt_word out_y;
        t_svt_word out_z;
        t_svt_word out_w;
        logic      out_last;
    } t_svt_result;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_NODE,
        KIND_VERTEX
    } t_svt_kind;

    typedef struct packed {
        t_svt_kind        kind;
        logic [ROW_W-1:0] row;
        t_svt_word        op_a;
        t_svt_word        op_b;
        t_svt_word        op_c;
        t_svt_word        op_d;
        t_svt_word        op_e;
        t_svt_word        op_f;
        logic             last;
    } t_svt_cmd;

endpackage
`default_nettype wire

### sv/sprite_vertex_transform.sv
// Top level of the sprite vertex transform: configuration register and the two halves.
//
//  Channel   Direction  Handshake                      Payload
//  item      in         push / full                    i_item  (t_svt_item)
//  result    out        pop / empty                    o_result (t_svt_result)
//  config    in/out     psel penable pwrite / pready   paddr pwdata prdata
//
// A vertex passes once through the twelve-lane multiply array, so vertices stream at one
// per cycle unless a node row or a full result queue holds them; a result goes through
// the command queue, the multiply stage and the result queue before it is visible.
// A node goes one transform row per cycle through the same array; a vertex behind a node
// waits for its last row. Reset: queues empty, both matrices identity, use_scene_graph set.
// A full result queue stalls vertices only; the command queue keeps filling until full.
`default_nettype none
module sprite_vertex_transform #(
    parameter int unsigned FRAC_BITS = svt_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  svt_pkg::t_svt_item                 i_item,
    output logic                               empty,
    input  logic                               pop,
    output svt_pkg::t_svt_result               o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [svt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [svt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [svt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import svt_pkg::*;

    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

    logic                r_use_sg;
    logic                cfg_sel;
    t_svt_cmd            cmd;
    logic                cmd_valid;
    logic                cmd_pop;
    logic [CNT_W-1:0]    res_count;
    logic                res_push;
    t_svt_result         res_data;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_USE_SCENE_GRAPH);
    assign prdata  = cfg_sel ? {{(CFG_DATA_W - 1){1'b0}}, r_use_sg} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_sg <= 1'b1;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_use_sg <= pwdata[0];
        end
    end

    svt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    svt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_use_sg    (r_use_sg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res_data  (res_data)
    );

    svt_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result),
        .o_count (res_count)
    );

endmodule
`default_nettype wire

### sv/svt_front.sv
// Front end: accepts items, classifies the command and queues it for the back end.
`default_nettype none
module svt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  svt_pkg::t_svt_item i_item,
    output svt_pkg::t_svt_cmd  o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);
    import svt_pkg::*;

    localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

    t_svt_cmd         r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    t_svt_cmd entry;
    logic     keep;
    logic     do_push;
    logic     do_pop;

    always_comb begin
        entry.row  = i_item.row_index;
        entry.op_a = i_item.operand_a;
        entry.op_b = i_item.operand_b;
        entry.op_c = i_item.operand_c;
        entry.op_d = i_item.operand_d;
        entry.op_e = i_item.operand_e;
        entry.op_f = i_item.operand_f;
        entry.last = i_item.last_vertex;
        unique case (i_item.command)
            CMD_LOAD_ROW: begin
                entry.kind = KIND_LOAD;
                keep       = 1'b1;
            end
            CMD_NODE: begin
                entry.kind = KIND_NODE;
                keep       = 1'b1;
            end
            CMD_VERTEX: begin
                entry.kind = KIND_VERTEX;
                keep       = 1'b1;
            end
            default: begin
                // The unused command is taken and dropped here.
                entry.kind = KIND_LOAD;
                keep       = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_count == CNT_W'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full && keep;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

endmodule
`default_nettype wire

### sv/svt_res_fifo.sv
// Result queue that holds finished vertices until they are taken.
`default_nettype none
module svt_res_fifo (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  svt_pkg::t_svt_result                      i_data,
    input  logic                                      i_pop,
    output logic                                      o_empty,
    output svt_pkg::t_svt_result                      o_data,
    output logic [$clog2(svt_pkg::RES_DEPTH + 1)-1:0] o_count
);
    import svt_pkg::*;

    localparam int unsigned PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

    t_svt_result      r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### sv/svt_back.sv
// Back end: matrix state and the shared multiply-accumulate array.
`default_nettype none
module svt_back #(
    parameter int unsigned FRAC_BITS = svt_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_use_sg,
    input  svt_pkg::t_svt_cmd                         i_cmd,
    input  logic                                      i_cmd_valid,
    output logic                                      o_cmd_pop,
    input  logic [$clog2(svt_pkg::RES_DEPTH + 1)-1:0] i_res_count,
    output logic                                      o_res_push,
    output svt_pkg::t_svt_result                      o_res_data
);
    import svt_pkg::*;

    localparam int unsigned FULL_W = 2 * DATA_W;
    localparam int unsigned PROD_W = FULL_W - FRAC_BITS;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned N_TERM = N_DIM - 1;
    localparam int unsigned CNT_W  = $clog2(RES_DEPTH + 1);

    localparam t_svt_word ONE_FX = {{(DATA_W - 1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [FULL_W-1:0] t_full;

    t_svt_word        r_local [N_DIM][N_DIM];
    t_svt_word        r_xform [N_DIM][N_DIM];
    logic [ROW_W-1:0] r_row_cnt;

    logic             r_s1_valid;
    logic             r_s1_vtx;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_last;
    t_prod            r_prod [N_DIM][N_TERM];
    t_svt_word        r_add [N_DIM];

    t_svt_word mcand  [N_DIM][N_TERM];
    t_svt_word mplier [N_DIM][N_TERM];
    t_svt_word addend [N_DIM];
    t_svt_word vtx    [N_TERM];
    t_svt_word lrow   [N_DIM];
    t_full     prod_full [N_DIM][N_TERM];
    t_full     prod_sh   [N_DIM][N_TERM];

    logic signed [SUM_W-1:0] sum [N_DIM];
    t_svt_word               sat [N_DIM];

    logic load_go;
    logic node_go;
    logic vtx_go;
    logic res_room;
    logic row_busy;

    // Issue. A vertex waits while a node row is still on its way into the
    // transform matrix, and while the result queue could not take it.
    assign row_busy = r_s1_valid && !r_s1_vtx;
    assign res_room = ({1'b0, i_res_count} + (CNT_W + 1)'(r_s1_vtx))
                      < (CNT_W + 1)'(RES_DEPTH);
    assign load_go  = i_cmd_valid && (i_cmd.kind == KIND_LOAD);
    assign node_go  = i_cmd_valid && (i_cmd.kind == KIND_NODE);
    assign vtx_go   = i_cmd_valid && (i_cmd.kind == KIND_VERTEX) && !row_busy && res_room;
    assign o_cmd_pop = load_go || vtx_go || (node_go && (r_row_cnt == ROW_W'(N_DIM - 1)));

    // Operand routing. A node works one transform row per cycle: the node's
    // third column is the identity, so column 2 is the local element as it is.
    always_comb begin
        vtx[0] = i_cmd.op_a;
        vtx[1] = i_cmd.op_b;
        vtx[2] = i_cmd.op_c;
        for (int c = 0; c < N_DIM; c++) begin
            lrow[c]   = r_local[r_row_cnt][c];
            addend[c] = '0;
            for (int k = 0; k < N_TERM; k++) begin
                mcand[c][k]  = '0;
                mplier[c][k] = '0;
            end
        end
        if (i_cmd.kind == KIND_VERTEX) begin
            for (int c = 0; c < N_DIM; c++) begin
                addend[c] = r_xform[N_DIM-1][c];
                for (int k = 0; k < N_TERM; k++) begin
                    mcand[c][k]  = vtx[k];
                    mplier[c][k] = r_xform[k][c];
                end
            end
        end else if (i_use_sg) begin
            mcand[0][0] = lrow[0];  mplier[0][0] = i_cmd.op_a;
            mcand[0][1] = lrow[1];  mplier[0][1] = i_cmd.op_c;
            mcand[1][0] = lrow[0];  mplier[1][0] = i_cmd.op_b;
            mcand[1][1] = lrow[1];  mplier[1][1] = i_cmd.op_d;
            addend[2]   = lrow[2];
            mcand[3][0] = lrow[0];  mplier[3][0] = i_cmd.op_e;
            mcand[3][1] = lrow[1];  mplier[3][1] = i_cmd.op_f;
            addend[3]   = lrow[3];
        end else begin
            for (int c = 0; c < N_DIM; c++) begin
                addend[c] = lrow[c];
            end
        end
        for (int c = 0; c < N_DIM; c++) begin
            for (int k = 0; k < N_TERM; k++) begin
                prod_full[c][k] = mcand[c][k] * mplier[c][k];
                prod_sh[c][k]   = prod_full[c][k] >>> FRAC_BITS;
            end
        end
    end

    // Accumulate and saturate each output lane.
    always_comb begin
        for (int c = 0; c < N_DIM; c++) begin
            sum[c] = SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1])
                   + SUM_W'(r_prod[c][2]) + SUM_W'(r_add[c]);
            if (sum[c] > SAT_MAX) begin
                sat[c] = SAT_MAX[DATA_W-1:0];
            end else if (sum[c] < SAT_MIN) begin
                sat[c] = SAT_MIN[DATA_W-1:0];
            end else begin
                sat[c] = sum[c][DATA_W-1:0];
            end
        end
    end

    assign o_res_push          = r_s1_valid && r_s1_vtx;
    assign o_res_data.out_x    = sat[0];
    assign o_res_data.out_y    = sat[1];
    assign o_res_data.out_z    = sat[2];
    assign o_res_data.out_w    = sat[3];
    assign o_res_data.out_last = r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_s1_valid <= 1'b0;
            r_s1_vtx   <= 1'b0;
            for (int r = 0; r < N_DIM; r++) begin
                for (int c = 0; c < N_DIM; c++) begin
                    r_local[r][c] <= (r == c) ? ONE_FX : '0;
                    r_xform[r][c] <= (r == c) ? ONE_FX : '0;
                end
            end
        end else begin
            r_s1_valid <= vtx_go || node_go;
            r_s1_vtx   <= vtx_go;
            if (node_go) begin
                r_row_cnt <= r_row_cnt + ROW_W'(1);
            end
            if (load_go) begin
                r_local[i_cmd.row][0] <= i_cmd.op_a;
                r_local[i_cmd.row][1] <= i_cmd.op_b;
                r_local[i_cmd.row][2] <= i_cmd.op_c;
                r_local[i_cmd.row][3] <= i_cmd.op_d;
            end
            if (row_busy) begin
                for (int c = 0; c < N_DIM; c++) begin
                    r_xform[r_s1_row][c] <= sat[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vtx_go || node_go) begin
            r_s1_row  <= r_row_cnt;
            r_s1_last <= i_cmd.last;
            for (int c = 0; c < N_DIM; c++) begin
                r_add[c] <= addend[c];
                for (int k = 0; k < N_TERM; k++) begin
                    r_prod[c][k] <= prod_sh[c][k][PROD_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

### sv/svt_checker.sv
// Port-level checks for the sprite vertex transform, bound to the top level.
`default_nettype none
module svt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input svt_pkg::t_svt_result           o_result,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [svt_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [svt_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [svt_pkg::CFG_DATA_W-1:0] prdata,
    input logic                           pready
);
    import svt_pkg::*;

    // Reset leaves both queues empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result is neither lost nor altered while the consumer stalls.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    // A write to use_scene_graph reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready
         && (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_USE_SCENE_GRAPH))
        ##1 (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_USE_SCENE_GRAPH)
        |-> (prdata == {{(CFG_DATA_W - 1){1'b0}}, $past(pwdata[0])}))
        else $error("configuration readback mismatch");

    // The configuration port never inserts wait states.
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("configuration port stalled");

endmodule

bind sprite_vertex_transform svt_checker u_svt_checker (.*);
`default_nettype wire

### verif/tb_sprite_vertex_transform.sv
// Self-checking testbench for the sprite vertex transform: item, result and APB ports.
`timescale 1ns / 100ps
module tb_sprite_vertex_transform;
    import svt_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned FRAC_BITS      = FRAC_BITS_DEF;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned PHASE_ITEMS    = 62;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_UNMAPPED = 1'b1;

    localparam t_svt_word FX_ONE = t_svt_word'(1 << FRAC_BITS);
    localparam t_svt_word FX_MAX = 32'sh7fffffff;
    localparam t_svt_word FX_MIN = 32'sh80000000;
    localparam longint    WORD_MAX = 64'sd2147483647;
    localparam longint    WORD_MIN = -64'sd2147483648;

    // Tracks both matrices and the composition flag, and holds the vertex results still owed.
    class vertex_scoreboard;
        t_svt_word   local_m[16];
        t_svt_word   xform_m[16];
        bit          compose;
        t_svt_result owed_q[$];
        int unsigned n_errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                local_m[i] = (i % 5 == 0) ? FX_ONE : '0;
                xform_m[i] = local_m[i];
            end
            compose  = 1'b1;
            n_errors = 0;
        endfunction

        function longint fx_mul(t_svt_word a, t_svt_word b);
            longint prod;
            prod = longint'(a) * longint'(b);
            return prod >>> FRAC_BITS;
        endfunction

        function t_svt_word sat_word(longint v);
            if (v > WORD_MAX) return FX_MAX;
            if (v < WORD_MIN) return FX_MIN;
            return t_svt_word'(v);
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void note_item(t_svt_item it);
            t_svt_word   node_m[16];
            t_svt_word   vin[3];
            t_svt_word   outs[4];
            t_svt_result res;
            longint      acc;
            case (it.command)
                CMD_LOAD_ROW: begin
                    local_m[it.row_index*4 + 0] = it.operand_a;
                    local_m[it.row_index*4 + 1] = it.operand_b;
                    local_m[it.row_index*4 + 2] = it.operand_c;
                    local_m[it.row_index*4 + 3] = it.operand_d;
                end
                CMD_NODE: begin
                    if (!compose) begin
                        xform_m = local_m;
                    end else begin
                        for (int i = 0; i < 16; i++) node_m[i] = (i % 5 == 0) ? FX_ONE : '0;
                        node_m[0] = it.operand_a;
                        node_m[1] = it.operand_b;
                        node_m[3] = it.operand_e;
                        node_m[4] = it.operand_c;
                        node_m[5] = it.operand_d;
                        node_m[7] = it.operand_f;
                        for (int row = 0; row < 4; row++) begin
                            for (int col = 0; col < 4; col++) begin
                                acc = 0;
                                for (int k = 0; k < 4; k++)
                                    acc += fx_mul(local_m[row*4 + k], node_m[k*4 + col]);
                                xform_m[row*4 + col] = sat_word(acc);
                            end
                        end
                    end
                end
                CMD_VERTEX: begin
                    vin[0] = it.operand_a;
                    vin[1] = it.operand_b;
                    vin[2] = it.operand_c;
                    // The implied w of 1 adds the bottom row unscaled.
                    for (int col = 0; col < 4; col++) begin
                        acc = xform_m[12 + col];
                        for (int k = 0; k < 3; k++)
                            acc += fx_mul(vin[k], xform_m[k*4 + col]);
                        outs[col] = sat_word(acc);
                    end
                    res.out_x    = outs[0];
                    res.out_y    = outs[1];
                    res.out_z    = outs[2];
                    res.out_w    = outs[3];
                    res.out_last = it.last_vertex;
                    owed_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, t_svt_word want, t_svt_word got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_svt_result got);
            t_svt_result want;
            if (owed_q.size() == 0) begin
                $error("result with nothing expected: x %0d y %0d z %0d w %0d last %0b",
                       got.out_x, got.out_y, got.out_z, got.out_w, got.out_last);
                n_errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("out_x", want.out_x, got.out_x);
            compare_field("out_y", want.out_y, got.out_y);
            compare_field("out_z", want.out_z, got.out_z);
            compare_field("out_w", want.out_w, got.out_w);
            compare_field("out_last", t_svt_word'({31'b0, want.out_last}),
                          t_svt_word'({31'b0, got.out_last}));
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    t_svt_item             i_item  = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    t_svt_result           o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    vertex_scoreboard sb = new();
    bit               send_steady  = 1'b0;
    bit               drain_steady = 1'b0;
    int unsigned      stall_cycles = 0;

    sprite_vertex_transform uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_svt_word fx_int(int v);
        return t_svt_word'(v * (1 << FRAC_BITS));
    endfunction

    // Values within +/- mag for most draws, with full-range words and corner values mixed in.
    function automatic t_svt_word rand_fx(int unsigned mag);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return t_svt_word'($urandom_range(0, 2*mag << FRAC_BITS))
                   - t_svt_word'(mag << FRAC_BITS);
        if (roll < 88) return t_svt_word'($urandom);
        case ($urandom_range(0, 5))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return '0;
            3: return FX_ONE;
            4: return -FX_ONE;
            default: return -1;
        endcase
    endfunction

    function automatic t_svt_item mk(logic [1:0] cmd, logic [1:0] row, t_svt_word a, t_svt_word b,
                                     t_svt_word c, t_svt_word d, t_svt_word e, t_svt_word f,
                                     logic last);
        t_svt_item it;
        it.command     = cmd;
        it.row_index   = row;
        it.operand_a   = a;
        it.operand_b   = b;
        it.operand_c   = c;
        it.operand_d   = d;
        it.operand_e   = e;
        it.operand_f   = f;
        it.last_vertex = last;
        return it;
    endfunction

    function automatic t_svt_word junk();
        return t_svt_word'($urandom);
    endfunction

    // push is left high after a transfer so that back-to-back items need no second assignment.
    task automatic send_item(input t_svt_item it);
        int unsigned gap;
        gap = pick_gap(send_steady);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    // Row loads and nodes give no result, so the block may still be busy once nothing is owed.
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {CFG_IDX_LSB{1'b0}}};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_USE_SCENE_GRAPH) begin
            sb.compose = data[0];
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata[0] !== data[0]) begin
                $error("use_scene_graph mismatch: expected %0b, actual %0b", data[0], prdata[0]);
                sb.n_errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One sprite: a few row loads, usually a node, then its vertices. Some sprites are
    // broken or replaced by noise. Returns the number of items that the block acts on.
    task automatic send_sprite(output int unsigned n_sent);
        int unsigned nrows, nvtx;
        bit          drop_last;
        t_svt_item   it;
        n_sent = 0;
        if ($urandom_range(0, 99) < 12) begin
            it = mk(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), junk(), junk(),
                    junk(), junk(), junk(), junk(), 1'($urandom_range(0, 1)));
            send_item(it);
            if (it.command != CMD_UNUSED) n_sent++;
            return;
        end
        nrows = $urandom_range(0, 4);
        for (int i = 0; i < nrows; i++) begin
            send_item(mk(CMD_LOAD_ROW, 2'($urandom_range(0, 3)), rand_fx(4), rand_fx(4),
                         rand_fx(4), rand_fx(4), junk(), junk(), 1'($urandom_range(0, 1))));
            n_sent++;
        end
        if ($urandom_range(0, 9) < 8) begin
            send_item(mk(CMD_NODE, 2'($urandom_range(0, 3)), rand_fx(4), rand_fx(4),
                         rand_fx(4), rand_fx(4), rand_fx(256), rand_fx(256),
                         1'($urandom_range(0, 1))));
            n_sent++;
        end
        nvtx      = $urandom_range(1, 8);
        drop_last = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < nvtx; i++) begin
            send_item(mk(CMD_VERTEX, 2'($urandom_range(0, 3)), rand_fx(512), rand_fx(512),
                         rand_fx(512), junk(), junk(), junk(),
                         (i == nvtx - 1) && !drop_last));
            n_sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: pop is held high across transfers unless a stall is drawn.
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap(drain_steady);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) sb.check_result(o_result);
        end
    end

    initial begin
        int unsigned phase_count, n_sent;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity transform at reset, with corner values passing straight through.
        send_item(mk(CMD_VERTEX, 2'd0, fx_int(1), fx_int(2), fx_int(3), '0, '0, '0, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd0, FX_MAX, FX_MIN, '0, '0, '0, '0, 1'b1));
        // A row load alone leaves the transform stale until the next node.
        send_item(mk(CMD_LOAD_ROW, 2'd0, fx_int(2), '0, '0, '0, '0, '0, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd1, FX_ONE, FX_ONE, FX_ONE, '0, '0, '0, 1'b0));
        send_item(mk(CMD_NODE, 2'd2, FX_ONE, '0, '0, FX_ONE, '0, '0, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd3, FX_ONE, FX_ONE, FX_ONE, '0, '0, '0, 1'b1));
        // Extreme matrices drive sums into saturation.
        send_item(mk(CMD_LOAD_ROW, 2'd1, FX_MAX, FX_MIN, FX_MAX, FX_MIN, '0, '0, 1'b1));
        send_item(mk(CMD_LOAD_ROW, 2'd2, FX_MIN, FX_MAX, FX_MIN, FX_MAX, '0, '0, 1'b0));
        send_item(mk(CMD_LOAD_ROW, 2'd3, FX_ONE, -FX_ONE, -1, FX_MAX, '0, '0, 1'b0));
        send_item(mk(CMD_NODE, 2'd0, FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MIN, 1'b1));
        send_item(mk(CMD_VERTEX, 2'd0, FX_MAX, FX_MIN, FX_MAX, '0, '0, '0, 1'b0));
        send_item(mk(CMD_UNUSED, 2'd3, -1, -1, -1, -1, -1, -1, 1'b1));
        send_item(mk(CMD_VERTEX, 2'd3, -1, -1, -1, -1, -1, -1, 1'b1));
        // Back to identity, then a node with tiny negative terms to show truncation downwards.
        send_item(mk(CMD_LOAD_ROW, 2'd0, FX_ONE, '0, '0, '0, '0, '0, 1'b0));
        send_item(mk(CMD_LOAD_ROW, 2'd1, '0, FX_ONE, '0, '0, '0, '0, 1'b0));
        send_item(mk(CMD_LOAD_ROW, 2'd2, '0, '0, FX_ONE, '0, '0, '0, 1'b0));
        send_item(mk(CMD_LOAD_ROW, 2'd3, '0, '0, '0, FX_ONE, '0, '0, 1'b0));
        send_item(mk(CMD_NODE, 2'd1, -1, FX_ONE >>> 1, -FX_ONE, 3, -1, FX_ONE, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd2, 1, -1, FX_ONE + 1, '0, '0, '0, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd1, '0, '0, '0, '0, '0, '0, 1'b1));

        // Without composition a node copies the local matrix.
        settle();
        cfg_write(REG_USE_SCENE_GRAPH, 32'd0);
        send_item(mk(CMD_NODE, 2'd0, fx_int(3), fx_int(-2), FX_ONE, FX_MAX, FX_MIN, 5, 1'b0));
        send_item(mk(CMD_VERTEX, 2'd0, FX_ONE, fx_int(2), fx_int(-3), '0, '0, '0, 1'b1));
        // A write to an unmapped register must leave composition off.
        settle();
        cfg_write(REG_UNMAPPED, 32'hffff_ffff);
        send_item(mk(CMD_LOAD_ROW, 2'd3, fx_int(7), fx_int(-7), '0, FX_ONE, '0, '0, 1'b0));
        send_item(mk(CMD_NODE, 2'd3, fx_int(2), '0, '0, fx_int(2), fx_int(9), fx_int(9), 1'b0));
        send_item(mk(CMD_VERTEX, 2'd0, FX_ONE, FX_ONE, FX_ONE, '0, '0, '0, 1'b1));

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            cfg_write(REG_USE_SCENE_GRAPH,
                      {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'd1
                      | ((p < 2) ? 32'(p == 0) : 32'($urandom_range(0, 1))));
            send_steady  = ($urandom_range(0, 3) == 0);
            drain_steady = ($urandom_range(0, 3) == 0);
            phase_count  = 0;
            while (phase_count < PHASE_ITEMS) begin
                send_sprite(n_sent);
                phase_count += n_sent;
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
